// ===== rtl/tvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants of the trilinear volume sampler: word formats,
// store geometry, fixed-point widths and register indexes.
// ----------------------------------------------------------------------------
package tvs_pkg;

    localparam int MAX_SLICES = 16;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int FRAC_BITS  = 8;

    localparam int SLICE_W = $clog2(MAX_SLICES);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);

    localparam int NUM_BANKS  = 8;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int BANK_AW    = (SLICE_W - 1) + (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int VOX_W  = 8;
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int WRC_W  = 2 * FRAC_BITS + 1;
    localparam int P_W    = VOX_W + WRC_W;
    localparam int SUM_W  = VOX_W + 3 * FRAC_BITS;
    localparam int OUT_W  = 16;
    localparam int SHIFT  = 3 * FRAC_BITS - 8;
    localparam int LIM_W  = 8;

    localparam logic [WGT_W-1:0] ONE_FRAC = WGT_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    localparam logic [4:0] SLICES_RESET = 5'd16;
    localparam logic [6:0] ROWS_RESET   = 7'd64;
    localparam logic [6:0] COLS_RESET   = 7'd64;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  voxel_slice;
        logic [5:0]  voxel_row;
        logic [5:0]  voxel_col;
        logic [7:0]  voxel_value;
        logic [11:0] slice_pos;
        logic [13:0] row_pos;
        logic [13:0] col_pos;
    } t_in_item;

    typedef struct packed {
        logic [15:0] intensity;
        logic        out_of_range;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/tvs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-port-write, single-port-read RAM with a registered read
// that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module tvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/trilinear_volume_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Voxel volume held in eight banks by corner parity, so that the eight
// corners of a sample cube are read in the same cycle, followed by a weight,
// multiply and adder-tree pipeline that returns the 8.8 trilinear blend.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+------------------------------
//   in       | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//   out      | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//   cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while the output is not stalled.
// The pipeline is input register, bank read, two multiplier stages, a
// partial-sum stage and the output register; all stages advance together.
// A stall on a valid output freezes all stages; nothing is lost or repeated.
// Reset clears valid bits and presets extents; the store is not cleared.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire tvs_pkg::t_in_item                  i_in_data,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output tvs_pkg::t_out_item                      o_out_data,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_cfg_valid,
    input  wire logic [tvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tvs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                    o_cfg_ready
);

    localparam int FB = tvs_pkg::FRAC_BITS;

    logic [4:0] r_slices;
    logic [6:0] r_rows;
    logic [6:0] r_cols;

    logic adv;

    logic              r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_o_v;
    logic              r_a_smp, r_b_smp, r_c_smp, r_d_smp, r_e_smp;
    logic              r_a_oor, r_b_oor, r_c_oor, r_d_oor, r_e_oor;
    tvs_pkg::t_in_item r_a_in;
    tvs_pkg::t_out_item r_o_data;

    logic [tvs_pkg::WRC_W-1:0] r_b_wrc [tvs_pkg::NUM_BANKS];
    logic [tvs_pkg::WGT_W-1:0] r_b_ws  [tvs_pkg::NUM_BANKS];
    logic [tvs_pkg::WGT_W-1:0] r_c_ws  [tvs_pkg::NUM_BANKS];
    logic [tvs_pkg::P_W-1:0]   r_c_p   [tvs_pkg::NUM_BANKS];
    logic [tvs_pkg::SUM_W-1:0] r_d_q   [tvs_pkg::NUM_BANKS];
    logic [tvs_pkg::SUM_W-1:0] r_e_sum [2];
    logic [tvs_pkg::VOX_W-1:0] rdata   [tvs_pkg::NUM_BANKS];

    logic [tvs_pkg::LIM_W-1:0] s_lim, r_lim, c_lim;
    logic [tvs_pkg::LIM_W-1:0] s_top, r_top, c_top;
    logic                      n_oor;

    logic [tvs_pkg::SLICE_W-1:0] a_s0;
    logic [tvs_pkg::ROW_W-1:0]   a_r0;
    logic [tvs_pkg::COL_W-1:0]   a_c0;
    logic [FB-1:0]               a_fs, a_fr, a_fc;
    logic                        wr_en;
    logic [tvs_pkg::BANK_W-1:0]  wr_bank;
    logic [tvs_pkg::BANK_AW-1:0] wr_addr;
    logic [tvs_pkg::SUM_W-1:0]   total;

    // Configuration.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slices <= tvs_pkg::SLICES_RESET;
            r_rows   <= tvs_pkg::ROWS_RESET;
            r_cols   <= tvs_pkg::COLS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tvs_pkg::CFG_SLICES: r_slices <= i_cfg_data[4:0];
                tvs_pkg::CFG_ROWS:   r_rows   <= i_cfg_data;
                tvs_pkg::CFG_COLS:   r_cols   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cube range check against the saturated extents.
    always_comb begin
        s_lim = (tvs_pkg::LIM_W'(r_slices) > tvs_pkg::LIM_W'(tvs_pkg::MAX_SLICES)) ?
                tvs_pkg::LIM_W'(tvs_pkg::MAX_SLICES) : tvs_pkg::LIM_W'(r_slices);
        r_lim = (tvs_pkg::LIM_W'(r_rows) > tvs_pkg::LIM_W'(tvs_pkg::MAX_ROWS)) ?
                tvs_pkg::LIM_W'(tvs_pkg::MAX_ROWS) : tvs_pkg::LIM_W'(r_rows);
        c_lim = (tvs_pkg::LIM_W'(r_cols) > tvs_pkg::LIM_W'(tvs_pkg::MAX_COLS)) ?
                tvs_pkg::LIM_W'(tvs_pkg::MAX_COLS) : tvs_pkg::LIM_W'(r_cols);
        s_top = tvs_pkg::LIM_W'(i_in_data.slice_pos[FB +: tvs_pkg::SLICE_W]) + 8'd2;
        r_top = tvs_pkg::LIM_W'(i_in_data.row_pos[FB +: tvs_pkg::ROW_W]) + 8'd2;
        c_top = tvs_pkg::LIM_W'(i_in_data.col_pos[FB +: tvs_pkg::COL_W]) + 8'd2;
        n_oor = (s_top > s_lim) || (r_top > r_lim) || (c_top > c_lim);
    end

    // All stages move together whenever the output register can take a word.
    assign adv        = !r_o_v || !i_out_stall;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_o_v <= r_e_v;
        end
    end

    // Stage A: input register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_in  <= i_in_data;
            r_a_smp <= (i_in_data.mode == tvs_pkg::MODE_SAMPLE);
            r_a_oor <= n_oor;
        end
    end

    assign a_s0 = r_a_in.slice_pos[FB +: tvs_pkg::SLICE_W];
    assign a_r0 = r_a_in.row_pos[FB +: tvs_pkg::ROW_W];
    assign a_c0 = r_a_in.col_pos[FB +: tvs_pkg::COL_W];
    assign a_fs = r_a_in.slice_pos[FB-1:0];
    assign a_fr = r_a_in.row_pos[FB-1:0];
    assign a_fc = r_a_in.col_pos[FB-1:0];

    assign wr_en   = adv && r_a_v && (r_a_in.mode == tvs_pkg::MODE_WRITE);
    assign wr_bank = {r_a_in.voxel_slice[0], r_a_in.voxel_row[0], r_a_in.voxel_col[0]};
    assign wr_addr = {r_a_in.voxel_slice[tvs_pkg::SLICE_W-1:1],
                      r_a_in.voxel_row[tvs_pkg::ROW_W-1:1],
                      r_a_in.voxel_col[tvs_pkg::COL_W-1:1]};

    // Stages B to D: bank reads, weight products and the voxel multiplies.
    for (genvar k = 0; k < tvs_pkg::NUM_BANKS; k++) begin : g_bank
        localparam logic [tvs_pkg::BANK_W-1:0] KB = tvs_pkg::BANK_W'(k);

        logic                         sel_s, sel_r, sel_c;
        logic [tvs_pkg::SLICE_W-1:0]  idx_s;
        logic [tvs_pkg::ROW_W-1:0]    idx_r;
        logic [tvs_pkg::COL_W-1:0]    idx_c;
        logic [tvs_pkg::BANK_AW-1:0]  rd_addr;
        logic [tvs_pkg::WGT_W-1:0]    w_s, w_r, w_c;
        logic [2*tvs_pkg::WGT_W-1:0]  wrc_full;
        logic [tvs_pkg::P_W+tvs_pkg::WGT_W-1:0] q_full;

        assign sel_s = KB[2] ^ a_s0[0];
        assign sel_r = KB[1] ^ a_r0[0];
        assign sel_c = KB[0] ^ a_c0[0];
        assign idx_s = a_s0 + tvs_pkg::SLICE_W'(sel_s);
        assign idx_r = a_r0 + tvs_pkg::ROW_W'(sel_r);
        assign idx_c = a_c0 + tvs_pkg::COL_W'(sel_c);
        assign rd_addr = {idx_s[tvs_pkg::SLICE_W-1:1], idx_r[tvs_pkg::ROW_W-1:1],
                          idx_c[tvs_pkg::COL_W-1:1]};

        assign w_s = sel_s ? {1'b0, a_fs} : (tvs_pkg::ONE_FRAC - {1'b0, a_fs});
        assign w_r = sel_r ? {1'b0, a_fr} : (tvs_pkg::ONE_FRAC - {1'b0, a_fr});
        assign w_c = sel_c ? {1'b0, a_fc} : (tvs_pkg::ONE_FRAC - {1'b0, a_fc});
        assign wrc_full = (2*tvs_pkg::WGT_W)'(w_r) * (2*tvs_pkg::WGT_W)'(w_c);

        tvs_ram #(
            .WIDTH (tvs_pkg::VOX_W),
            .DEPTH (tvs_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en && (wr_bank == KB)),
            .i_waddr (wr_addr),
            .i_wdata (r_a_in.voxel_value),
            .i_re    (adv),
            .i_raddr (rd_addr),
            .o_rdata (rdata[k])
        );

        assign q_full = (tvs_pkg::P_W+tvs_pkg::WGT_W)'(r_c_p[k])
                      * (tvs_pkg::P_W+tvs_pkg::WGT_W)'(r_c_ws[k]);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_b_wrc[k] <= wrc_full[tvs_pkg::WRC_W-1:0];
                r_b_ws[k]  <= w_s;
                r_c_p[k]   <= tvs_pkg::P_W'(rdata[k]) * tvs_pkg::P_W'(r_b_wrc[k]);
                r_c_ws[k]  <= r_b_ws[k];
                r_d_q[k]   <= q_full[tvs_pkg::SUM_W-1:0];
            end
        end
    end

    // Stages B to E: flags, partial sums and the output register.
    assign total = r_e_sum[0] + r_e_sum[1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_smp <= r_a_smp;
            r_b_oor <= r_a_oor;
            r_c_smp <= r_b_smp;
            r_c_oor <= r_b_oor;
            r_d_smp <= r_c_smp;
            r_d_oor <= r_c_oor;
            r_e_smp <= r_d_smp;
            r_e_oor <= r_d_oor;
            r_e_sum[0] <= r_d_q[0] + r_d_q[1] + r_d_q[2] + r_d_q[3];
            r_e_sum[1] <= r_d_q[4] + r_d_q[5] + r_d_q[6] + r_d_q[7];
            r_o_data.out_of_range <= r_e_smp && r_e_oor;
            r_o_data.intensity    <= (r_e_smp && !r_e_oor) ?
                                     total[tvs_pkg::SHIFT +: tvs_pkg::OUT_W] : '0;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o_data;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_range |-> o_out_data.intensity == '0)
        else $error("out-of-range result carries a nonzero intensity");

    a_max_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.intensity <= 16'hFF00)
        else $error("intensity above 255.0");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable({r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_o_v}))
        else $error("pipeline moved while stalled");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_e_v && !r_e_smp |=> o_out_data.intensity == '0 && !o_out_data.out_of_range)
        else $error("write word produced a nonzero result");

endmodule
`default_nettype wire

// ===== tb/sv/trilinear_volume_sampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilinear_volume_sampler_tb
// Drives voxel writes and sample words into the sampler under several volume
// settings and handshake idling patterns, predicts every result word with an
// in-bench trilinear blend, and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler_tb;
    import tvs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int VOLUME_SIZE = MAX_SLICES * MAX_ROWS * MAX_COLS;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    class blend_scoreboard;
        bit [7:0] voxels [VOLUME_SIZE];
        int unsigned span_s, span_r, span_c;
        t_out_item due_blends [$];

        function new();
            set_register(CFG_SLICES, 7'(SLICES_RESET));
            set_register(CFG_ROWS, ROWS_RESET);
            set_register(CFG_COLS, COLS_RESET);
        endfunction

        // Values over the store size saturate to it; slices use only bits 4:0.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            int unsigned v;
            v = 32'(val);
            case (idx)
                CFG_SLICES: begin
                    v = 32'(val[4:0]);
                    span_s = (v > MAX_SLICES) ? MAX_SLICES : v;
                end
                CFG_ROWS: begin
                    span_r = (v > MAX_ROWS) ? MAX_ROWS : v;
                end
                CFG_COLS: begin
                    span_c = (v > MAX_COLS) ? MAX_COLS : v;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_word(t_in_item w);
            t_out_item due;
            int unsigned s0, r0, c0, a, b, d;
            longint unsigned ws [2], wr [2], wc [2];
            longint unsigned sum;
            due = '0;
            if (w.mode == MODE_WRITE) begin
                voxels[(int'(w.voxel_slice) * MAX_ROWS + int'(w.voxel_row)) * MAX_COLS
                       + int'(w.voxel_col)] = w.voxel_value;
            end else begin
                s0 = 32'(w.slice_pos >> FRAC_BITS);
                r0 = 32'(w.row_pos >> FRAC_BITS);
                c0 = 32'(w.col_pos >> FRAC_BITS);
                if (s0 + 2 > span_s || r0 + 2 > span_r || c0 + 2 > span_c) begin
                    due.out_of_range = 1'b1;
                end else begin
                    ws[1] = 64'(w.slice_pos[FRAC_BITS-1:0]);
                    wr[1] = 64'(w.row_pos[FRAC_BITS-1:0]);
                    wc[1] = 64'(w.col_pos[FRAC_BITS-1:0]);
                    ws[0] = (64'd1 << FRAC_BITS) - ws[1];
                    wr[0] = (64'd1 << FRAC_BITS) - wr[1];
                    wc[0] = (64'd1 << FRAC_BITS) - wc[1];
                    sum = 0;
                    for (int k = 0; k < 8; k++) begin
                        a = (k >> 2) & 1;
                        b = (k >> 1) & 1;
                        d = k & 1;
                        sum += longint'(voxels[((s0 + a) * MAX_ROWS + r0 + b) * MAX_COLS
                                               + c0 + d]) * ws[a] * wr[b] * wc[d];
                    end
                    due.intensity = 16'(sum >> (3 * FRAC_BITS - 8));
                end
            end
            due_blends = {due_blends, due};
        endfunction

        function string check_word(t_out_item got);
            t_out_item due;
            string msg;
            msg = "";
            if (due_blends.size() == 0) begin
                return $sformatf("result word with none due: intensity %h flag %b",
                                 got.intensity, got.out_of_range);
            end
            due = due_blends.pop_front();
            if (got.intensity !== due.intensity) begin
                msg = $sformatf("intensity %h, due %h ", got.intensity, due.intensity);
            end
            if (got.out_of_range !== due.out_of_range) begin
                msg = {msg, $sformatf("out_of_range %b, due %b",
                                      got.out_of_range, due.out_of_range)};
            end
            return msg;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in_item              i_in_data;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall;
    logic                  i_cfg_valid;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_cfg_ready;

    blend_scoreboard blends;
    bit              voxel_loaded [VOLUME_SIZE];
    int              send_gap_pct;
    int              stall_pct;
    int              words_sent;
    int              mismatch_count;
    int              cycle_count;

    trilinear_volume_sampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        string msg;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            msg = blends.check_word(o_out_data);
            if (msg != "") begin
                report_mismatch(msg);
            end
        end
    end

    function automatic t_in_item noise_word();
        t_in_item w;
        w.mode        = 1'($urandom_range(1));
        w.voxel_slice = 4'($urandom_range(15));
        w.voxel_row   = 6'($urandom_range(63));
        w.voxel_col   = 6'($urandom_range(63));
        w.voxel_value = 8'($urandom_range(255));
        w.slice_pos   = 12'($urandom_range(4095));
        w.row_pos     = 14'($urandom_range(16383));
        w.col_pos     = 14'($urandom_range(16383));
        return w;
    endfunction

    function automatic int unsigned pick_frac();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 0;
        end else if (r == 1) begin
            return (1 << FRAC_BITS) - 1;
        end
        return $urandom_range((1 << FRAC_BITS) - 1);
    endfunction

    function automatic int unsigned pick_lower(input int unsigned span);
        int unsigned top;
        top = span - 2;
        if ($urandom_range(99) < 60 && top > 3) begin
            top = 3;
        end
        return $urandom_range(top);
    endfunction

    // The word stays on the bus until a clock edge sees no stall.
    task automatic send_item(input t_in_item w);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        blends.note_word(w);
        words_sent++;
    endtask

    task automatic load_voxel(input int unsigned s, input int unsigned r,
                              input int unsigned c, input logic [7:0] val);
        t_in_item w;
        w             = noise_word();
        w.mode        = MODE_WRITE;
        w.voxel_slice = 4'(s);
        w.voxel_row   = 6'(r);
        w.voxel_col   = 6'(c);
        w.voxel_value = val;
        voxel_loaded[(s * MAX_ROWS + r) * MAX_COLS + c] = 1'b1;
        send_item(w);
    endtask

    // Corners of an in-range cube that were never written get loaded first.
    task automatic sample_at(input logic [11:0] sp, input logic [13:0] rp,
                             input logic [13:0] cp);
        t_in_item    w;
        int unsigned s0, r0, c0, s, r, c;
        s0 = 32'(sp >> FRAC_BITS);
        r0 = 32'(rp >> FRAC_BITS);
        c0 = 32'(cp >> FRAC_BITS);
        if (s0 + 2 <= blends.span_s && r0 + 2 <= blends.span_r
            && c0 + 2 <= blends.span_c) begin
            for (int k = 0; k < 8; k++) begin
                s = s0 + ((k >> 2) & 1);
                r = r0 + ((k >> 1) & 1);
                c = c0 + (k & 1);
                if (!voxel_loaded[(s * MAX_ROWS + r) * MAX_COLS + c]) begin
                    load_voxel(s, r, c, 8'($urandom_range(255)));
                end
            end
        end
        w           = noise_word();
        w.mode      = MODE_SAMPLE;
        w.slice_pos = sp;
        w.row_pos   = rp;
        w.col_pos   = cp;
        send_item(w);
    endtask

    task automatic random_step();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(1) == 0) begin
                load_voxel($urandom_range(4), $urandom_range(4), $urandom_range(4),
                           8'($urandom_range(255)));
            end else begin
                load_voxel($urandom_range(MAX_SLICES - 1), $urandom_range(MAX_ROWS - 1),
                           $urandom_range(MAX_COLS - 1), 8'($urandom_range(255)));
            end
        end else if (pick < 85 && blends.span_s >= 2 && blends.span_r >= 2
                     && blends.span_c >= 2) begin
            sample_at(12'((pick_lower(blends.span_s) << FRAC_BITS) | pick_frac()),
                      14'((pick_lower(blends.span_r) << FRAC_BITS) | pick_frac()),
                      14'((pick_lower(blends.span_c) << FRAC_BITS) | pick_frac()));
        end else begin
            sample_at(12'($urandom_range(4095)), 14'($urandom_range(16383)),
                      14'($urandom_range(16383)));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (blends.due_blends.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        blends.set_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] slices,
                             input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols,
                             input int gap, input int stall, input int budget);
        int target;
        wait_drained();
        write_register(CFG_NONE, 7'($urandom_range(127)));
        write_register(CFG_SLICES, slices);
        write_register(CFG_ROWS, rows);
        write_register(CFG_COLS, cols);
        send_gap_pct = gap;
        stall_pct    = stall;
        target       = words_sent + budget;
        while (words_sent < target) begin
            random_step();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_gap_pct   = 0;
        stall_pct      = 0;
        words_sent     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        blends         = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extreme values and corners first, then cubes that leave each axis.
        load_voxel(0, 0, 0, 8'h00);
        load_voxel(MAX_SLICES - 1, MAX_ROWS - 1, MAX_COLS - 1, 8'hFF);
        load_voxel(0, 0, 1, 8'hFF);
        sample_at(12'h080, 14'h0080, 14'h0080);
        sample_at(12'hEFF, 14'h3EFF, 14'h3EFF);
        sample_at(12'h000, 14'h0000, 14'h0000);
        sample_at(12'hF00, 14'h0000, 14'h0000);
        sample_at(12'h000, 14'h3F00, 14'h0000);
        sample_at(12'h000, 14'h0000, 14'h3F00);
        sample_at(12'hFFF, 14'h3FFF, 14'h3FFF);

        while (words_sent < 220) begin
            random_step();
        end
        run_phase(7'd2, 7'd2, 7'd2, 52, 0, 200);
        run_phase(7'h7F, 7'd127, 7'd127, 0, 52, 220);
        run_phase(7'd0, 7'd1, 7'd0, 13, 13, 60);
        run_phase(7'd5, 7'd17, 7'd40, 0, 0, 240);
        run_phase(7'd16, 7'd64, 7'd64, 52, 0, 240);
        run_phase(7'h63, 7'd64, 7'd2, 0, 52, 220);
        run_phase(7'd9, 7'd33, 7'd64, 13, 13, 240);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
